// ----- rtl/core/gcme_pkg.sv -----
package gcme_pkg;

    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_ROWS_DEF    = 64;

    // locate divider: nonnegative offset from the grid corner over the cell size
    localparam int DIV_W = 22;
    localparam int DVS_W = 11;

    localparam int MUL_W = 16;

    localparam int COST_W = 16;
    localparam int SUM_W  = 28;
    localparam logic [COST_W-1:0] COST_ONE  = 16'd32768;
    localparam logic [SUM_W-1:0]  SUM_LIMIT = 28'd134217728;
    localparam int LATTICE_MM = 100;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_POINT = 3'd2,
        OP_DISK  = 3'd3,
        OP_SUM   = 3'd4,
        OP_ALL   = 3'd5,
        OP_MARK  = 3'd6,
        OP_APPLY = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X  = 3'd0,
        CFG_ORIGIN_Y  = 3'd1,
        CFG_CELL_SIZE = 3'd2,
        CFG_CELLS_X   = 3'd3,
        CFG_CELLS_Y   = 3'd4,
        CFG_RADIUS    = 3'd5,
        CFG_GROW      = 3'd6,
        CFG_SHRINK    = 3'd7
    } cfg_idx_t;

endpackage

// ----- rtl/core/gcme_div.sv -----
module gcme_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [gcme_pkg::DIV_W-1:0]  dividend,
    input  logic [gcme_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [gcme_pkg::DIV_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(gcme_pkg::DIV_W + 1);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [gcme_pkg::DVS_W-1:0]  rem_reg, rem_next;
    logic [gcme_pkg::DVS_W-1:0]  dvs_reg, dvs_next;
    logic [gcme_pkg::DIV_W-1:0]  quo_reg, quo_next;
    logic [gcme_pkg::DVS_W:0]    shifted;
    logic [gcme_pkg::DVS_W:0]    diff;
    logic                        ge;

    always_comb begin
        shifted   = {rem_reg, quo_reg[gcme_pkg::DIV_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        ge        = shifted >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(gcme_pkg::DIV_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[gcme_pkg::DVS_W-1:0] : shifted[gcme_pkg::DVS_W-1:0];
            quo_next = {quo_reg[gcme_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/gcme_mul.sv -----
module gcme_mul (
    input  logic                          aclk,
    input  logic [gcme_pkg::MUL_W-1:0]    a,
    input  logic [gcme_pkg::MUL_W-1:0]    b,
    output logic [2*gcme_pkg::MUL_W-1:0]  prod
);

    logic [2*gcme_pkg::MUL_W-1:0] prod_reg, prod_next;

    assign prod_next = a * b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/core/grid_cost_map_engine.sv -----
// Cost grid engine: one command per item, one result item per command. The block
// is busy while a command runs; a result waits in an output register, so the next
// item is taken while it is pending. Point scale finds the cell with two divisions
// of the shared divider. Disk commands run a center lookup, then step over the
// lattice samples, locating each sample inside the radius with two divisions, then
// sweep the grid cell by cell. Scale-all sweeps the grid the same way; apply sweeps
// the full depth MAX_COLUMNS*MAX_ROWS. All products go through one shared registered
// 16x16 multiplier. After reset a clearing pass over all MAX_COLUMNS*MAX_ROWS
// entries of the mark memories runs before the first item.
module grid_cost_map_engine #(
    parameter int MAX_COLUMNS = gcme_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = gcme_pkg::MAX_ROWS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [19:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_opcode,
    input  logic signed [19:0]  s_pos_x,
    input  logic signed [19:0]  s_pos_y,
    input  logic                s_action,
    input  logic [12:0]         s_cell_index,
    input  logic [15:0]         s_cell_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_cost_value,
    output logic [27:0]         m_cost_sum,
    output logic                m_status
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(DEPTH + 1);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int DW    = gcme_pkg::DIV_W;
    localparam int MW    = gcme_pkg::MUL_W;

    typedef enum logic [17:0] {
        S_CLEAR  = 18'h00001,
        S_IDLE   = 18'h00002,
        S_AREA   = 18'h00004,
        S_DISP   = 18'h00008,
        S_RDWAIT = 18'h00010,
        S_LOC    = 18'h00020,
        S_LDIVX  = 18'h00040,
        S_LDIVY  = 18'h00080,
        S_LIDX   = 18'h00100,
        S_DR2    = 18'h00200,
        S_DXCHK  = 18'h00400,
        S_DXSQ   = 18'h00800,
        S_DYCHK  = 18'h01000,
        S_DYSQ   = 18'h02000,
        S_SWRD   = 18'h04000,
        S_SWEVAL = 18'h08000,
        S_SWWR   = 18'h10000,
        S_DONE   = 18'h20000
    } state_t;

    typedef enum logic [1:0] {
        RET_POINT  = 2'd0,
        RET_CENTER = 2'd1,
        RET_SAMPLE = 2'd2
    } ret_t;

    // configuration
    logic signed [19:0] origin_x_reg, origin_y_reg;
    logic [10:0]        cell_size_reg, radius_reg;
    logic [7:0]         cells_x_reg;
    logic [6:0]         cells_y_reg;
    logic [15:0]        grow_reg, shrink_reg;

    state_t             state_reg, state_next;
    ret_t               ret_reg, ret_next;
    gcme_pkg::op_t      op_reg, op_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [KW-1:0]      area_reg, area_next;
    logic signed [19:0] px_reg, px_next, py_reg, py_next;
    logic               act_reg, act_next;
    logic [12:0]        ci_reg, ci_next;
    logic [15:0]        cv_reg, cv_next;
    logic signed [21:0] lx_reg, lx_next, ly_reg, ly_next;
    logic [DW-1:0]      col_reg, col_next;
    logic signed [12:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [21:0]        sqx_reg, sqx_next, r2_reg, r2_next;
    logic               status_reg, status_next;
    logic [15:0]        value_reg, value_next;
    logic [27:0]        sum_reg, sum_next;
    logic               m_valid_reg, m_valid_next;
    logic [15:0]        m_cost_value_reg, m_cost_value_next;
    logic [27:0]        m_cost_sum_reg, m_cost_sum_next;
    logic               m_status_reg, m_status_next;

    // memories
    logic [15:0] cost_mem [DEPTH];
    logic        mark_mem [DEPTH];
    logic        cov_mem  [DEPTH];
    logic [15:0] cost_rd_reg;
    logic        mark_rd_reg, cov_rd_reg;
    logic [AW-1:0] rd_addr;
    logic          cost_we, mark_we, cov_we;
    logic [AW-1:0] cost_wa, cov_wa;
    logic [15:0]   cost_wd;
    logic          mark_wd, cov_wd;

    // shared units
    logic [MW-1:0]    mul_a, mul_b;
    logic [2*MW-1:0]  prod;
    logic             div_start, div_done;
    logic [DW-1:0]    div_dividend, div_quot;

    // derived values
    logic [CW-1:0]      cols_used;
    logic [RW-1:0]      rows_used;
    logic [10:0]        cs_eff;
    logic signed [22:0] dx, dy;
    logic signed [12:0] r_s;
    logic [12:0]        ox_abs, oy_abs;
    logic [17:0]        scaled;
    logic [15:0]        scaled_sat;
    logic [15:0]        gain;
    logic [KW-1:0]      area_now, sweep_end;
    logic [28:0]        sum_add;
    logic [22:0]        d2;
    logic               do_ret, ret_ok;
    logic [AW-1:0]      ret_idx;

    gcme_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    gcme_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cs_eff),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb begin
        cols_used  = ({24'd0, cells_x_reg} > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(cells_x_reg);
        rows_used  = ({25'd0, cells_y_reg} > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(cells_y_reg);
        cs_eff     = (cell_size_reg == 11'd0) ? 11'd1 : cell_size_reg;
        dx         = 23'(lx_reg) - 23'(origin_x_reg);
        dy         = 23'(ly_reg) - 23'(origin_y_reg);
        r_s        = $signed({2'b00, radius_reg});
        ox_abs     = ox_reg[12] ? 13'(-ox_reg) : 13'(ox_reg);
        oy_abs     = oy_reg[12] ? 13'(-oy_reg) : 13'(oy_reg);
        scaled     = prod[31:14];
        scaled_sat = (scaled > 18'(gcme_pkg::COST_ONE)) ? gcme_pkg::COST_ONE : scaled[15:0];
        gain       = act_reg ? shrink_reg : grow_reg;
        area_now   = KW'(prod);
        sweep_end  = (op_reg == gcme_pkg::OP_APPLY) ? KW'(DEPTH) : area_reg;
        sum_add    = {1'b0, sum_reg} + 29'(cost_rd_reg);
        d2         = {1'b0, sqx_reg} + {1'b0, prod[21:0]};
        rd_addr    = (state_reg == S_DISP) ? AW'(ci_reg) : k_reg[AW-1:0];
    end

    always_comb begin
        state_next        = state_reg;
        ret_next          = ret_reg;
        op_next           = op_reg;
        k_next            = k_reg;
        area_next         = area_reg;
        px_next           = px_reg;
        py_next           = py_reg;
        act_next          = act_reg;
        ci_next           = ci_reg;
        cv_next           = cv_reg;
        lx_next           = lx_reg;
        ly_next           = ly_reg;
        col_next          = col_reg;
        ox_next           = ox_reg;
        oy_next           = oy_reg;
        sqx_next          = sqx_reg;
        r2_next           = r2_reg;
        status_next       = status_reg;
        value_next        = value_reg;
        sum_next          = sum_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_cost_value_next = m_cost_value_reg;
        m_cost_sum_next   = m_cost_sum_reg;
        m_status_next     = m_status_reg;
        cost_we           = 1'b0;
        cost_wa           = k_reg[AW-1:0];
        cost_wd           = scaled_sat;
        mark_we           = 1'b0;
        mark_wd           = 1'b0;
        cov_we            = 1'b0;
        cov_wa            = k_reg[AW-1:0];
        cov_wd            = 1'b0;
        mul_a             = MW'(cols_used);
        mul_b             = MW'(rows_used);
        div_start         = 1'b0;
        div_dividend      = DW'(dx);
        do_ret            = 1'b0;
        ret_ok            = 1'b0;
        ret_idx           = AW'(prod) + AW'(col_reg);

        case (state_reg)
            S_CLEAR: begin
                mark_we = 1'b1;
                cov_we  = 1'b1;
                k_next  = k_reg + 1'b1;
                if (k_reg == KW'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next     = gcme_pkg::op_t'(s_opcode);
                    px_next     = s_pos_x;
                    py_next     = s_pos_y;
                    act_next    = s_action;
                    ci_next     = s_cell_index;
                    cv_next     = s_cell_value;
                    status_next = 1'b0;
                    value_next  = '0;
                    sum_next    = '0;
                    state_next  = S_AREA;
                end
            end
            S_AREA: begin
                state_next = S_DISP;
            end
            S_DISP: begin
                area_next = area_now;
                case (op_reg)
                    gcme_pkg::OP_WRITE: begin
                        if (KW'(ci_reg) < area_now && {19'd0, ci_reg} < DEPTH) begin
                            cost_we = 1'b1;
                            cost_wa = AW'(ci_reg);
                            cost_wd = (cv_reg > gcme_pkg::COST_ONE) ? gcme_pkg::COST_ONE
                                                                     : cv_reg;
                        end else begin
                            status_next = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    gcme_pkg::OP_READ: begin
                        if (KW'(ci_reg) < area_now && {19'd0, ci_reg} < DEPTH) begin
                            state_next = S_RDWAIT;
                        end else begin
                            status_next = 1'b1;
                            state_next  = S_DONE;
                        end
                    end
                    gcme_pkg::OP_POINT: begin
                        lx_next    = 22'(px_reg);
                        ly_next    = 22'(py_reg);
                        ret_next   = RET_POINT;
                        state_next = S_LOC;
                    end
                    gcme_pkg::OP_DISK, gcme_pkg::OP_SUM, gcme_pkg::OP_MARK: begin
                        lx_next    = 22'(px_reg);
                        ly_next    = 22'(py_reg);
                        ret_next   = RET_CENTER;
                        state_next = S_LOC;
                    end
                    default: begin
                        k_next     = '0;
                        state_next = S_SWRD;
                    end
                endcase
            end
            S_RDWAIT: begin
                value_next = cost_rd_reg;
                state_next = S_DONE;
            end
            S_LOC: begin
                if (cols_used == '0 || rows_used == '0 || dx < 0 || dy < 0) begin
                    do_ret = 1'b1;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = DW'(dx);
                    state_next   = S_LDIVX;
                end
            end
            S_LDIVX: begin
                if (div_done) begin
                    col_next     = div_quot;
                    div_start    = 1'b1;
                    div_dividend = DW'(dy);
                    state_next   = S_LDIVY;
                end
            end
            S_LDIVY: begin
                if (div_done) begin
                    if (col_reg < DW'(cols_used) && div_quot < DW'(rows_used)) begin
                        mul_a      = MW'(div_quot);
                        mul_b      = MW'(cols_used);
                        state_next = S_LIDX;
                    end else begin
                        do_ret = 1'b1;
                    end
                end
            end
            S_LIDX: begin
                do_ret = 1'b1;
                ret_ok = 1'b1;
            end
            S_DR2: begin
                r2_next    = prod[21:0];
                ox_next    = -r_s;
                state_next = S_DXCHK;
            end
            S_DXCHK: begin
                if (ox_reg > r_s) begin
                    k_next     = '0;
                    state_next = S_SWRD;
                end else begin
                    mul_a      = MW'(ox_abs);
                    mul_b      = MW'(ox_abs);
                    oy_next    = -r_s;
                    state_next = S_DXSQ;
                end
            end
            S_DXSQ: begin
                sqx_next   = prod[21:0];
                state_next = S_DYCHK;
            end
            S_DYCHK: begin
                if (oy_reg > r_s) begin
                    ox_next    = ox_reg + 13'(gcme_pkg::LATTICE_MM);
                    state_next = S_DXCHK;
                end else begin
                    mul_a      = MW'(oy_abs);
                    mul_b      = MW'(oy_abs);
                    state_next = S_DYSQ;
                end
            end
            S_DYSQ: begin
                if (d2 > {1'b0, r2_reg}) begin
                    oy_next    = oy_reg + 13'(gcme_pkg::LATTICE_MM);
                    state_next = S_DYCHK;
                end else begin
                    lx_next    = 22'(px_reg) + 22'(ox_reg);
                    ly_next    = 22'(py_reg) + 22'(oy_reg);
                    ret_next   = RET_SAMPLE;
                    state_next = S_LOC;
                end
            end
            S_SWRD: begin
                if (op_reg != gcme_pkg::OP_POINT && k_reg >= sweep_end) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_SWEVAL;
                end
            end
            S_SWEVAL: begin
                mul_a      = cost_rd_reg;
                mul_b      = gain;
                k_next     = k_reg + 1'b1;
                state_next = S_SWRD;
                case (op_reg)
                    gcme_pkg::OP_POINT, gcme_pkg::OP_ALL: begin
                        k_next     = k_reg;
                        state_next = S_SWWR;
                    end
                    gcme_pkg::OP_DISK: begin
                        cov_we = cov_rd_reg;
                        if (cov_rd_reg) begin
                            k_next     = k_reg;
                            state_next = S_SWWR;
                        end
                    end
                    gcme_pkg::OP_SUM: begin
                        cov_we = cov_rd_reg;
                        if (cov_rd_reg) begin
                            sum_next = (sum_add > 29'(gcme_pkg::SUM_LIMIT))
                                       ? gcme_pkg::SUM_LIMIT : sum_add[27:0];
                        end
                    end
                    gcme_pkg::OP_MARK: begin
                        cov_we  = cov_rd_reg;
                        mark_we = cov_rd_reg;
                        mark_wd = 1'b1;
                    end
                    gcme_pkg::OP_APPLY: begin
                        mark_we = 1'b1;
                        if (mark_rd_reg && k_reg < area_reg) begin
                            k_next     = k_reg;
                            state_next = S_SWWR;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SWWR: begin
                cost_we = 1'b1;
                if (op_reg == gcme_pkg::OP_POINT) begin
                    state_next = S_DONE;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_SWRD;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_cost_value_next = value_reg;
                    m_cost_sum_next   = sum_reg;
                    m_status_next     = status_reg;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // end of a cell lookup
        if (do_ret) begin
            case (ret_reg)
                RET_POINT: begin
                    if (ret_ok) begin
                        k_next     = KW'(ret_idx);
                        state_next = S_SWRD;
                    end else begin
                        status_next = 1'b1;
                        state_next  = S_DONE;
                    end
                end
                RET_CENTER: begin
                    status_next = !ret_ok;
                    mul_a       = MW'(radius_reg);
                    mul_b       = MW'(radius_reg);
                    state_next  = S_DR2;
                end
                default: begin
                    if (ret_ok) begin
                        cov_we = 1'b1;
                        cov_wa = ret_idx;
                        cov_wd = 1'b1;
                    end
                    oy_next    = oy_reg + 13'(gcme_pkg::LATTICE_MM);
                    state_next = S_DYCHK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cost_we) begin
            cost_mem[cost_wa] <= cost_wd;
        end
        cost_rd_reg <= cost_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[k_reg[AW-1:0]] <= mark_wd;
        end
        mark_rd_reg <= mark_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cov_we) begin
            cov_mem[cov_wa] <= cov_wd;
        end
        cov_rd_reg <= cov_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            k_reg         <= '0;
            m_valid_reg   <= 1'b0;
            origin_x_reg  <= -20'sd20000;
            origin_y_reg  <= 20'sd0;
            cell_size_reg <= 11'd200;
            cells_x_reg   <= 8'd100;
            cells_y_reg   <= 7'd50;
            radius_reg    <= 11'd500;
            grow_reg      <= 16'd16548;
            shrink_reg    <= 16'd8192;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (gcme_pkg::cfg_idx_t'(cfg_index))
                    gcme_pkg::CFG_ORIGIN_X:  origin_x_reg  <= $signed(cfg_wr_data);
                    gcme_pkg::CFG_ORIGIN_Y:  origin_y_reg  <= $signed(cfg_wr_data);
                    gcme_pkg::CFG_CELL_SIZE: cell_size_reg <= cfg_wr_data[10:0];
                    gcme_pkg::CFG_CELLS_X:   cells_x_reg   <= cfg_wr_data[7:0];
                    gcme_pkg::CFG_CELLS_Y:   cells_y_reg   <= cfg_wr_data[6:0];
                    gcme_pkg::CFG_RADIUS:    radius_reg    <= cfg_wr_data[10:0];
                    gcme_pkg::CFG_GROW:      grow_reg      <= cfg_wr_data[15:0];
                    default:                 shrink_reg    <= cfg_wr_data[15:0];
                endcase
            end
        end
        ret_reg          <= ret_next;
        op_reg           <= op_next;
        area_reg         <= area_next;
        px_reg           <= px_next;
        py_reg           <= py_next;
        act_reg          <= act_next;
        ci_reg           <= ci_next;
        cv_reg           <= cv_next;
        lx_reg           <= lx_next;
        ly_reg           <= ly_next;
        col_reg          <= col_next;
        ox_reg           <= ox_next;
        oy_reg           <= oy_next;
        sqx_reg          <= sqx_next;
        r2_reg           <= r2_next;
        status_reg       <= status_next;
        value_reg        <= value_next;
        sum_reg          <= sum_next;
        m_cost_value_reg <= m_cost_value_next;
        m_cost_sum_reg   <= m_cost_sum_next;
        m_status_reg     <= m_status_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_cost_value = m_cost_value_reg;
    assign m_cost_sum   = m_cost_sum_reg;
    assign m_status     = m_status_reg;

endmodule

// ----- tb/grid_cost_map_engine_tb.sv -----
module grid_cost_map_engine_tb;

    typedef struct {
        logic [15:0] value;
        logic [27:0] sum;
        logic        status;
    } cost_result_t;

    typedef struct {
        gcme_pkg::op_t op;
        longint        x;
        longint        y;
        bit            act;
        int            ci;
        int            cv;
        bit            typed;
        cost_result_t  res;
    } cmd_row_t;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               cfg_wr_en = 0;
    logic [2:0]         cfg_index = '0;
    logic [19:0]        cfg_wr_data = '0;
    logic               s_valid = 0;
    logic               s_ready;
    logic [2:0]         s_opcode = '0;
    logic signed [19:0] s_pos_x = '0;
    logic signed [19:0] s_pos_y = '0;
    logic               s_action = 0;
    logic [12:0]        s_cell_index = '0;
    logic [15:0]        s_cell_value = '0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [15:0]        m_cost_value;
    logic [27:0]        m_cost_sum;
    logic               m_status;

    grid_cost_map_engine dut (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    initial begin
        #400000000;
        $display("TEST FAILED");
        $finish;
    end

    // model state
    longint      org_x, org_y;
    int unsigned cell_mm, ncols, nrows, radius, grow_g, shrink_g;
    logic [15:0] cost_mem [0:8191];
    bit          mark_mem [0:8191];
    bit          hit_mem  [0:8191];
    bit          loaded   [0:8191];

    cost_result_t result_q[$];
    cmd_row_t     dir_rows[$];
    int           mismatches = 0;
    int           burst_left = 4;
    bit           hold_req = 0;

    function automatic int unsigned cols_eff();
        return ncols > 128 ? 128 : ncols;
    endfunction

    function automatic int unsigned rows_eff();
        return nrows > 64 ? 64 : nrows;
    endfunction

    function automatic bit find_cell(longint x, longint y, output int idx);
        longint cs, dx, dy, col, row;
        cs = cell_mm ? cell_mm : 1;
        dx = x - org_x;
        dy = y - org_y;
        idx = 0;
        if (cols_eff() == 0 || rows_eff() == 0 || dx < 0 || dy < 0) return 0;
        col = dx / cs;
        row = dy / cs;
        if (col >= cols_eff() || row >= rows_eff()) return 0;
        idx = int'(col + row * cols_eff());
        return 1;
    endfunction

    function automatic logic [15:0] scaled_cost(logic [15:0] v, bit act);
        longint p;
        p = (longint'(v) * (act ? shrink_g : grow_g)) >>> 14;
        return p > 32768 ? 16'd32768 : p[15:0];
    endfunction

    function automatic bit cover_disk(longint x, longint y);
        longint r, n, ox, oy;
        int idx;
        r = radius;
        n = (2 * r) / gcme_pkg::LATTICE_MM;
        for (int k = 0; k < 8192; k++) hit_mem[k] = 0;
        for (longint i = 0; i <= n; i++) begin
            ox = i * gcme_pkg::LATTICE_MM - r;
            for (longint j = 0; j <= n; j++) begin
                oy = j * gcme_pkg::LATTICE_MM - r;
                if (ox * ox + oy * oy <= r * r && find_cell(x + ox, y + oy, idx))
                    hit_mem[idx] = 1;
            end
        end
        return find_cell(x, y, idx);
    endfunction

    function automatic cost_result_t predict_cost(cmd_row_t c);
        cost_result_t r;
        int unsigned area;
        int idx;
        longint acc;
        area = cols_eff() * rows_eff();
        r.value = 0;
        r.sum = 0;
        r.status = 0;
        acc = 0;
        case (c.op)
            gcme_pkg::OP_WRITE:
                if (c.ci < area) cost_mem[c.ci] = c.cv > 32768 ? 16'd32768 : 16'(c.cv);
                else r.status = 1;
            gcme_pkg::OP_READ:
                if (c.ci < area) r.value = cost_mem[c.ci];
                else r.status = 1;
            gcme_pkg::OP_POINT:
                if (find_cell(c.x, c.y, idx)) cost_mem[idx] = scaled_cost(cost_mem[idx], c.act);
                else r.status = 1;
            gcme_pkg::OP_DISK, gcme_pkg::OP_SUM, gcme_pkg::OP_MARK: begin
                r.status = !cover_disk(c.x, c.y);
                for (int k = 0; k < area; k++) begin
                    if (hit_mem[k]) begin
                        if (c.op == gcme_pkg::OP_DISK)
                            cost_mem[k] = scaled_cost(cost_mem[k], c.act);
                        else if (c.op == gcme_pkg::OP_SUM) begin
                            acc += cost_mem[k];
                            if (acc > 134217728) acc = 134217728;
                        end else mark_mem[k] = 1;
                    end
                end
                r.sum = acc[27:0];
            end
            gcme_pkg::OP_ALL:
                for (int k = 0; k < area; k++) cost_mem[k] = scaled_cost(cost_mem[k], c.act);
            default: begin
                for (int k = 0; k < area; k++)
                    if (mark_mem[k]) cost_mem[k] = scaled_cost(cost_mem[k], c.act);
                for (int k = 0; k < 8192; k++) mark_mem[k] = 0;
            end
        endcase
        return r;
    endfunction

    task automatic write_reg(gcme_pkg::cfg_idx_t idx, longint v);
        @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wr_data <= v[19:0];
        @(posedge aclk);
        cfg_wr_en <= 0;
        case (idx)
            gcme_pkg::CFG_ORIGIN_X:  org_x = longint'($signed(v[19:0]));
            gcme_pkg::CFG_ORIGIN_Y:  org_y = longint'($signed(v[19:0]));
            gcme_pkg::CFG_CELL_SIZE: cell_mm = v[10:0];
            gcme_pkg::CFG_CELLS_X:   ncols = v[7:0];
            gcme_pkg::CFG_CELLS_Y:   nrows = v[6:0];
            gcme_pkg::CFG_RADIUS:    radius = v[10:0];
            gcme_pkg::CFG_GROW:      grow_g = v[15:0];
            default:                 shrink_g = v[15:0];
        endcase
    endtask

    task automatic send_cmd(cmd_row_t c);
        logic [19:0] px, py;
        cost_result_t r;
        px = c.x[19:0];
        py = c.y[19:0];
        c.x = longint'($signed(px));
        c.y = longint'($signed(py));
        s_valid <= 1;
        s_opcode <= c.op;
        s_pos_x <= px;
        s_pos_y <= py;
        s_action <= c.act;
        s_cell_index <= c.ci[12:0];
        s_cell_value <= c.cv[15:0];
        c.ci = c.ci & 16'h1fff;
        c.cv = c.cv & 16'hffff;
        do @(posedge aclk); while (!s_ready);
        r = predict_cost(c);
        result_q.insert(result_q.size(), c.typed ? c.res : r);
        if (c.op == gcme_pkg::OP_WRITE && c.ci < cols_eff() * rows_eff()) loaded[c.ci] = 1;
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
        end
    endtask

    function automatic cmd_row_t mk(gcme_pkg::op_t op, longint x, longint y, bit act,
                                    int ci, int cv);
        cmd_row_t c;
        c.op = op;
        c.x = x;
        c.y = y;
        c.act = act;
        c.ci = ci;
        c.cv = cv;
        c.typed = 0;
        c.res = '{16'd0, 28'd0, 1'b0};
        return c;
    endfunction

    task automatic add_row(gcme_pkg::op_t op, longint x, longint y, bit act, int ci, int cv,
                           bit typed = 0, int ev = 0, bit est = 0);
        cmd_row_t c;
        c = mk(op, x, y, act, ci, cv);
        c.typed = typed;
        c.res = '{16'(ev), 28'd0, est};
        dir_rows.insert(dir_rows.size(), c);
    endtask

    task automatic wait_idle();
        s_valid <= 0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic load_grid();
        for (int k = 0; k < cols_eff() * rows_eff(); k++)
            if (!loaded[k])
                send_cmd(mk(gcme_pkg::OP_WRITE, 0, 0, 0, k, $urandom_range(0, 32768)));
    endtask

    function automatic longint near_coord(longint org, int unsigned span);
        longint cs;
        cs = cell_mm ? cell_mm : 1;
        if (span == 0) span = 5;
        return org - cs + $urandom_range(0, (span + 2) * cs);
    endfunction

    task automatic random_cmds(int count);
        cmd_row_t c;
        int unsigned area, pick;
        for (int n = 0; n < count; n++) begin
            area = cols_eff() * rows_eff();
            pick = $urandom_range(0, 99);
            c = mk(gcme_pkg::OP_READ, near_coord(org_x, cols_eff()),
                   near_coord(org_y, rows_eff()),
                   $urandom_range(0, 1), area ? $urandom_range(0, area - 1) : 0,
                   $urandom_range(0, 32768));
            if (pick < 10) begin
                c.op = gcme_pkg::op_t'($urandom_range(0, 6));
                c.x = $urandom_range(0, 20'hfffff);
                c.y = $urandom_range(0, 20'hfffff);
                c.ci = $urandom_range(0, 8191);
                c.cv = $urandom_range(0, 65535);
            end else if (pick < 25) c.op = gcme_pkg::OP_WRITE;
            else if (pick < 38) c.op = gcme_pkg::OP_READ;
            else if (pick < 55) c.op = gcme_pkg::OP_POINT;
            else if (pick < 68) c.op = gcme_pkg::OP_DISK;
            else if (pick < 81) c.op = gcme_pkg::OP_SUM;
            else if (pick < 85) c.op = gcme_pkg::OP_ALL;
            else if (pick < 98) c.op = gcme_pkg::OP_MARK;
            else c.op = gcme_pkg::OP_APPLY;
            if (n == 50) hold_req = 1;
            send_cmd(c);
        end
    endtask

    task automatic set_phase(longint ox, longint oy, int cs, int cx, int cy, int r,
                             int gg, int sg);
        wait_idle();
        write_reg(gcme_pkg::CFG_ORIGIN_X, ox);
        write_reg(gcme_pkg::CFG_ORIGIN_Y, oy);
        write_reg(gcme_pkg::CFG_CELL_SIZE, cs);
        write_reg(gcme_pkg::CFG_CELLS_X, cx);
        write_reg(gcme_pkg::CFG_CELLS_Y, cy);
        write_reg(gcme_pkg::CFG_RADIUS, r);
        write_reg(gcme_pkg::CFG_GROW, gg);
        write_reg(gcme_pkg::CFG_SHRINK, sg);
        load_grid();
    endtask

    // result checker and receiver stall pattern
    initial begin
        cost_result_t e;
        int mode, mode_left, hold_left;
        bit held;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        held = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result item");
                end else begin
                    e = result_q.pop_front();
                    if (m_cost_value !== e.value || m_cost_sum !== e.sum ||
                        m_status !== e.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp value %0d sum %0d status %0d, got %0d %0d %0d",
                                     e.value, e.sum, e.status,
                                     m_cost_value, m_cost_sum, m_status);
                    end
                end
            end
            if (hold_req && !held) begin
                held = 1;
                hold_left = 3000;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(64, 256);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 0;
            end else if (mode == 0) m_ready <= 1;
            else if (mode == 1) m_ready <= $urandom_range(0, 1);
            else m_ready <= ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        org_x = -20000;
        org_y = 0;
        cell_mm = 200;
        ncols = 100;
        nrows = 50;
        radius = 500;
        grow_g = 16548;
        shrink_g = 8192;
        for (int k = 0; k < 8192; k++) begin
            cost_mem[k] = 0;
            mark_mem[k] = 0;
            loaded[k] = 0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1;

        // reset configuration, only cells that are written first are read back or summed
        add_row(gcme_pkg::OP_WRITE, 0, 0, 0, 0, 32768, 1, 0, 0);
        add_row(gcme_pkg::OP_READ, 0, 0, 0, 0, 0, 1, 32768, 0);
        add_row(gcme_pkg::OP_WRITE, 0, 0, 0, 4999, 65535, 1, 0, 0);
        add_row(gcme_pkg::OP_READ, 0, 0, 0, 4999, 0, 1, 32768, 0);
        add_row(gcme_pkg::OP_WRITE, 0, 0, 0, 5000, 77, 1, 0, 1);
        add_row(gcme_pkg::OP_READ, 0, 0, 0, 8191, 0, 1, 0, 1);
        add_row(gcme_pkg::OP_WRITE, 0, 0, 0, 1, 0, 1, 0, 0);
        add_row(gcme_pkg::OP_READ, 0, 0, 0, 1, 0, 1, 0, 0);
        add_row(gcme_pkg::OP_POINT, -20000, 0, 0, 0, 0);
        add_row(gcme_pkg::OP_READ, 0, 0, 0, 0, 0, 1, 32768, 0);
        add_row(gcme_pkg::OP_POINT, -20001, 0, 0, 0, 0, 1, 0, 1);
        add_row(gcme_pkg::OP_POINT, 524287, 524287, 1, 0, 0, 1, 0, 1);
        add_row(gcme_pkg::OP_POINT, -524288, -524288, 0, 0, 0, 1, 0, 1);
        add_row(gcme_pkg::OP_POINT, -19900, 100, 1, 0, 0);
        add_row(gcme_pkg::OP_READ, 0, 0, 0, 0, 0);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                add_row(gcme_pkg::OP_WRITE, 0, 0, 0, c + r * 100, $urandom_range(0, 32768));
        add_row(gcme_pkg::OP_DISK, -19900, 100, 0, 0, 0);
        add_row(gcme_pkg::OP_SUM, -19900, 100, 1, 0, 0);
        add_row(gcme_pkg::OP_SUM, -20100, -100, 0, 0, 0);
        add_row(gcme_pkg::OP_MARK, -19900, 100, 0, 0, 0);
        add_row(gcme_pkg::OP_MARK, -20100, -100, 1, 0, 0);
        add_row(gcme_pkg::OP_APPLY, 0, 0, 1, 0, 0);
        add_row(gcme_pkg::OP_APPLY, 0, 0, 0, 0, 0);
        add_row(gcme_pkg::OP_DISK, -19700, 300, 1, 0, 0);
        add_row(gcme_pkg::OP_SUM, -19900, 100, 0, 0, 0);
        add_row(gcme_pkg::OP_READ, 0, 0, 0, 101, 0);
        foreach (dir_rows[k]) send_cmd(dir_rows[k]);

        set_phase(0, 0, 100, 8, 4, 150, 20000, 12000);
        random_cmds(200);
        set_phase(-1000, -2000, 50, 16, 8, 250, 65535, 65535);
        random_cmds(200);
        set_phase(-524288, 524287, 2000, 3, 2, 2000, 16384, 0);
        random_cmds(10);
        set_phase(300, -300, 0, 20, 10, 0, 0, 1);
        random_cmds(150);
        set_phase(100, 100, 400, 0, 5, 300, 16548, 8192);
        random_cmds(80);
        set_phase(-524288, -524288, 60, 255, 1, 300, 16384, 16383);
        random_cmds(30);
        set_phase(-524288, -524288, 60, 2, 127, 300, 16384, 16383);
        random_cmds(30);
        set_phase(7000, 9000, 1999, 1, 1, 120, 30000, 4000);
        random_cmds(120);
        set_phase(5000, -7000, 333, 12, 6, 250, 17000, 15000);
        random_cmds(480);

        s_valid <= 0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
